FILE: sv/tftp_lockstep_transfer_engine_defines.svh
// ----------------------------------------------------------------------------
// tftp lock-step transfer engine assertion macros
// concurrent checks on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef TFTP_LOCKSTEP_TRANSFER_ENGINE_DEFINES_SVH
`define TFTP_LOCKSTEP_TRANSFER_ENGINE_DEFINES_SVH

`ifndef SYNTH

// same-cycle implication
`define TLTE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlte assertion failed");

// next-cycle implication
`define TLTE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlte assertion failed");

`else

`define TLTE_ASSERT_IMPL(label, ante, cons)
`define TLTE_ASSERT_NEXT(label, ante, cons)

`endif

`endif

FILE: sv/tlte_pkg.sv
// ----------------------------------------------------------------------------
// tlte_pkg
// shared types and codes of the tftp lock-step transfer engine
// ----------------------------------------------------------------------------
package tlte_pkg;

    localparam int CMD_W   = 3;
    localparam int OP_W    = 3;
    localparam int BLOCK_W = 16;
    localparam int SIZE_W  = 10;
    localparam int IOS_W   = 2;
    localparam int ACT_W   = 3;
    localparam int ERR_W   = 3;
    localparam int STAT_W  = 2;
    localparam int TICK_W  = 8;
    localparam int TOTAL_W = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // command codes
    localparam logic [CMD_W-1:0] CMD_START      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TICK       = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PACKET     = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FETCH_DONE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STORE_DONE = 3'd4;

    // tftp opcodes
    localparam logic [OP_W-1:0] OP_DATA  = 3'd3;
    localparam logic [OP_W-1:0] OP_ACK   = 3'd4;
    localparam logic [OP_W-1:0] OP_ERROR = 3'd5;

    // io status
    localparam logic [IOS_W-1:0] IO_OK       = 2'd0;
    localparam logic [IOS_W-1:0] IO_NO_SPACE = 2'd1;

    // actions
    localparam logic [ACT_W-1:0] ACT_NONE  = 3'd0;
    localparam logic [ACT_W-1:0] ACT_DATA  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_ACK   = 3'd2;
    localparam logic [ACT_W-1:0] ACT_ERR   = 3'd3;
    localparam logic [ACT_W-1:0] ACT_FETCH = 3'd4;
    localparam logic [ACT_W-1:0] ACT_STORE = 3'd5;

    // tftp error codes
    localparam logic [ERR_W-1:0] ERR_UNDEF     = 3'd0;
    localparam logic [ERR_W-1:0] ERR_DISK_FULL = 3'd3;

    // transfer status
    localparam logic [STAT_W-1:0] ST_BUSY  = 2'd0;
    localparam logic [STAT_W-1:0] ST_DONE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_ABORT = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RETX      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL     = 2'd2;

    typedef enum logic [2:0] {
        EV_START,
        EV_TICK,
        EV_PACKET,
        EV_FETCH_DONE,
        EV_STORE_DONE,
        EV_IGNORE
    } ev_kind_t;

    typedef struct packed {
        ev_kind_t            kind;
        logic                is_data;
        logic                is_ack;
        logic                is_error;
        logic [BLOCK_W-1:0]  blk;
        logic [SIZE_W-1:0]   size;
        logic                io_ok;
        logic                io_no_space;
    } ev_t;

    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [BLOCK_W-1:0] out_block;
        logic [SIZE_W-1:0]  out_size;
        logic [ERR_W-1:0]   error_code;
        logic [STAT_W-1:0]  status;
    } res_t;

    typedef struct packed {
        logic               direction;
        logic [TICK_W-1:0]  retransmit_ticks;
        logic [TOTAL_W-1:0] total_timeout;
    } cfg_t;

endpackage

FILE: sv/tlte_ifs.sv
// ----------------------------------------------------------------------------
// tlte channel interfaces
// valid/ready channels for command and result transactions
// ----------------------------------------------------------------------------
interface tlte_cmd_if import tlte_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [OP_W-1:0]    pkt_opcode;
    logic [BLOCK_W-1:0] pkt_block;
    logic [SIZE_W-1:0]  payload_size;
    logic [IOS_W-1:0]   io_status;

    modport source (
        output valid, command, pkt_opcode, pkt_block, payload_size, io_status,
        input  ready
    );

    modport sink (
        input  valid, command, pkt_opcode, pkt_block, payload_size, io_status,
        output ready
    );
endinterface

interface tlte_res_if import tlte_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ACT_W-1:0]   action;
    logic [BLOCK_W-1:0] out_block;
    logic [SIZE_W-1:0]  out_size;
    logic [ERR_W-1:0]   error_code;
    logic [STAT_W-1:0]  status;

    modport source (
        output valid, action, out_block, out_size, error_code, status,
        input  ready
    );

    modport sink (
        input  valid, action, out_block, out_size, error_code, status,
        output ready
    );
endinterface

FILE: sv/tlte_front.sv
// ----------------------------------------------------------------------------
// tlte_front
// decodes an incoming command transaction into an event for the queue
// ----------------------------------------------------------------------------
module tlte_front import tlte_pkg::*; #(
    parameter int SEGMENT_BYTES = 512
) (
    input  logic [CMD_W-1:0]   command,
    input  logic [OP_W-1:0]    pkt_opcode,
    input  logic [BLOCK_W-1:0] pkt_block,
    input  logic [SIZE_W-1:0]  payload_size,
    input  logic [IOS_W-1:0]   io_status,
    output ev_t                ev
);

    always_comb
    begin
        case (command)
            CMD_START:      ev.kind = EV_START;
            CMD_TICK:       ev.kind = EV_TICK;
            CMD_PACKET:     ev.kind = EV_PACKET;
            CMD_FETCH_DONE: ev.kind = EV_FETCH_DONE;
            CMD_STORE_DONE: ev.kind = EV_STORE_DONE;
            default:        ev.kind = EV_IGNORE;
        endcase
        ev.is_data     = (pkt_opcode == OP_DATA);
        ev.is_ack      = (pkt_opcode == OP_ACK);
        ev.is_error    = (pkt_opcode == OP_ERROR);
        ev.blk         = pkt_block;
        // oversized payload is clipped to one segment
        if (int'(payload_size) > SEGMENT_BYTES)
        begin
            ev.size = SIZE_W'(SEGMENT_BYTES);
        end
        else
        begin
            ev.size = payload_size;
        end
        ev.io_ok       = (io_status == IO_OK);
        ev.io_no_space = (io_status == IO_NO_SPACE);
    end

endmodule

FILE: sv/tlte_queue.sv
// ----------------------------------------------------------------------------
// tlte_queue
// small event queue between the front and the back part
// ----------------------------------------------------------------------------
module tlte_queue import tlte_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  ev_t  push_ev,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output ev_t  head_ev
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ev_t              mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_next;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head_ev   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_ev;
        end
    end

endmodule

FILE: sv/tlte_back.sv
// ----------------------------------------------------------------------------
// tlte_back
// lock-step transfer state machine with registered result stage
// ----------------------------------------------------------------------------
module tlte_back import tlte_pkg::*; #(
    parameter int SEGMENT_BYTES = 512
) (
    input  logic clk,
    input  logic rst_n,
    input  cfg_t cfg,
    input  logic ev_valid,
    input  ev_t  ev,
    output logic ev_pop,
    output logic res_valid,
    input  logic res_ready,
    output res_t res
);

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_FETCH,
        PH_WACK,
        PH_WDATA,
        PH_STORE,
        PH_LINGER
    } phase_t;

    phase_t             phase_reg,  phase_next;
    logic [BLOCK_W-1:0] block_reg,  block_next;
    logic [SIZE_W-1:0]  size_reg,   size_next;
    logic [TICK_W-1:0]  tick_reg,   tick_next;
    logic [TOTAL_W-1:0] total_reg,  total_next;
    logic               valid_reg;
    res_t               res_reg,    res_next;

    logic [BLOCK_W-1:0] prev_block;
    logic [BLOCK_W-1:0] block_inc;
    logic [TICK_W-1:0]  tick_inc;
    logic [TOTAL_W:0]   total_sum;
    logic               waiting;

    assign ev_pop    = ev_valid && (!valid_reg || res_ready);
    assign res_valid = valid_reg;
    assign res       = res_reg;

    assign prev_block = block_reg - 1'b1;
    assign block_inc  = block_reg + 1'b1;
    assign tick_inc   = tick_reg + 1'b1;
    assign total_sum  = {1'b0, total_reg} + {{(TOTAL_W + 1 - TICK_W){1'b0}},
                                             cfg.retransmit_ticks};

    always_comb
    begin
        waiting    = phase_reg inside {PH_WACK, PH_WDATA, PH_LINGER};
        phase_next = phase_reg;
        block_next = block_reg;
        size_next  = size_reg;
        tick_next  = tick_reg;
        total_next = total_reg;
        res_next   = '0;

        case (ev.kind)
            EV_START:
            begin
                tick_next  = '0;
                total_next = '0;
                size_next  = '0;
                block_next = BLOCK_W'(1);
                if (!cfg.direction)
                begin
                    phase_next         = PH_FETCH;
                    res_next.action    = ACT_FETCH;
                    res_next.out_block = BLOCK_W'(1);
                end
                else
                begin
                    phase_next      = PH_WDATA;
                    res_next.action = ACT_ACK;
                end
            end
            EV_TICK:
            begin
                if (waiting)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= cfg.retransmit_ticks)
                    begin
                        tick_next = '0;
                        if (phase_reg == PH_LINGER)
                        begin
                            phase_next      = PH_IDLE;
                            res_next.status = ST_DONE;
                        end
                        else
                        begin
                            total_next = total_sum[TOTAL_W] ? '1 : total_sum[TOTAL_W-1:0];
                            if (total_sum >= {1'b0, cfg.total_timeout})
                            begin
                                phase_next      = PH_IDLE;
                                res_next.status = ST_ABORT;
                            end
                            else if (phase_reg == PH_WACK)
                            begin
                                res_next.action    = ACT_DATA;
                                res_next.out_block = block_reg;
                                res_next.out_size  = size_reg;
                            end
                            else
                            begin
                                res_next.action    = ACT_ACK;
                                res_next.out_block = prev_block;
                            end
                        end
                    end
                end
            end
            EV_PACKET:
            begin
                if (waiting)
                begin
                    tick_next = '0;
                    if (phase_reg == PH_LINGER)
                    begin
                        phase_next      = PH_IDLE;
                        res_next.status = ST_DONE;
                        if (ev.is_data && ev.blk == block_reg)
                        begin
                            res_next.action    = ACT_ACK;
                            res_next.out_block = block_reg;
                        end
                    end
                    else if (ev.is_error)
                    begin
                        phase_next      = PH_IDLE;
                        res_next.status = ST_ABORT;
                    end
                    else if (phase_reg == PH_WACK && ev.is_ack)
                    begin
                        if (ev.blk == block_reg)
                        begin
                            if (int'(size_reg) < SEGMENT_BYTES)
                            begin
                                phase_next      = PH_IDLE;
                                res_next.status = ST_DONE;
                            end
                            else
                            begin
                                block_next         = block_inc;
                                phase_next         = PH_FETCH;
                                res_next.action    = ACT_FETCH;
                                res_next.out_block = block_inc;
                            end
                        end
                        else if (ev.blk == prev_block)
                        begin
                            res_next.action    = ACT_DATA;
                            res_next.out_block = block_reg;
                            res_next.out_size  = size_reg;
                        end
                    end
                    else if (phase_reg == PH_WDATA && ev.is_data)
                    begin
                        if (ev.blk == block_reg)
                        begin
                            size_next          = ev.size;
                            phase_next         = PH_STORE;
                            res_next.action    = ACT_STORE;
                            res_next.out_block = block_reg;
                            res_next.out_size  = ev.size;
                        end
                        else if (ev.blk == prev_block)
                        begin
                            res_next.action    = ACT_ACK;
                            res_next.out_block = prev_block;
                        end
                    end
                end
            end
            EV_FETCH_DONE:
            begin
                if (phase_reg == PH_FETCH)
                begin
                    if (!ev.io_ok)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.action     = ACT_ERR;
                        res_next.error_code = ERR_UNDEF;
                        res_next.status     = ST_ABORT;
                    end
                    else
                    begin
                        size_next          = ev.size;
                        tick_next          = '0;
                        total_next         = '0;
                        phase_next         = PH_WACK;
                        res_next.action    = ACT_DATA;
                        res_next.out_block = block_reg;
                        res_next.out_size  = ev.size;
                    end
                end
            end
            EV_STORE_DONE:
            begin
                if (phase_reg == PH_STORE)
                begin
                    if (!ev.io_ok)
                    begin
                        phase_next          = PH_IDLE;
                        res_next.action     = ACT_ERR;
                        res_next.error_code = ev.io_no_space ? ERR_DISK_FULL : ERR_UNDEF;
                        res_next.status     = ST_ABORT;
                    end
                    else
                    begin
                        tick_next          = '0;
                        res_next.action    = ACT_ACK;
                        res_next.out_block = block_reg;
                        if (int'(size_reg) == SEGMENT_BYTES)
                        begin
                            total_next = '0;
                            block_next = block_inc;
                            phase_next = PH_WDATA;
                        end
                        else
                        begin
                            phase_next = PH_LINGER;
                        end
                    end
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            block_reg <= '0;
            size_reg  <= '0;
            tick_reg  <= '0;
            total_reg <= '0;
            valid_reg <= 1'b0;
            res_reg   <= '0;
        end
        else if (ev_pop)
        begin
            phase_reg <= phase_next;
            block_reg <= block_next;
            size_reg  <= size_next;
            tick_reg  <= tick_next;
            total_reg <= total_next;
            valid_reg <= 1'b1;
            res_reg   <= res_next;
        end
        else if (res_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

endmodule

FILE: sv/tftp_lockstep_transfer_engine.sv
// ----------------------------------------------------------------------------
// tftp_lockstep_transfer_engine
// lock-step tftp data-phase engine, sender or receiver by configuration
// ----------------------------------------------------------------------------
// One command transaction in gives exactly one result transaction out, in order.
// The engine takes one command per clock unless the queue is full: the front
// decodes it into a queue of QUEUE_DEPTH entries, and the back runs the transfer
// state machine on one queued event per cycle, unless a held result stalls it,
// into a single result register behind the queue. A stalled result port only
// blocks input once the queue is full. Configuration writes take effect on the
// next cycle and are meant for an idle engine.
// ----------------------------------------------------------------------------
`include "tftp_lockstep_transfer_engine_defines.svh"

module tftp_lockstep_transfer_engine import tlte_pkg::*; #(
    parameter int SEGMENT_BYTES = 512,
    parameter int QUEUE_DEPTH   = 2
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    tlte_cmd_if.sink              cmd,
    tlte_res_if.source            rsp
);

    cfg_t cfg_reg;
    ev_t  front_ev;
    ev_t  head_ev;
    logic queue_full;
    logic queue_not_empty;
    logic ev_pop;
    logic push;
    res_t res;
    logic end_act_ok;
    logic err_fields_ok;
    logic size_act_ok;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction        <= 1'b0;
            cfg_reg.retransmit_ticks <= TICK_W'(5);
            cfg_reg.total_timeout    <= TOTAL_W'(25);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECTION: cfg_reg.direction        <= cfg_wdata[0];
                REG_RETX:      cfg_reg.retransmit_ticks <= cfg_wdata[TICK_W-1:0];
                REG_TOTAL:     cfg_reg.total_timeout    <= cfg_wdata[TOTAL_W-1:0];
                default:       cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cmd.ready = !queue_full;
    assign push      = cmd.valid && !queue_full;

    tlte_front #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_front (
        .command      (cmd.command),
        .pkt_opcode   (cmd.pkt_opcode),
        .pkt_block    (cmd.pkt_block),
        .payload_size (cmd.payload_size),
        .io_status    (cmd.io_status),
        .ev           (front_ev)
    );

    tlte_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_ev   (front_ev),
        .full      (queue_full),
        .pop       (ev_pop),
        .not_empty (queue_not_empty),
        .head_ev   (head_ev)
    );

    tlte_back #(
        .SEGMENT_BYTES (SEGMENT_BYTES)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ev_valid  (queue_not_empty),
        .ev        (head_ev),
        .ev_pop    (ev_pop),
        .res_valid (rsp.valid),
        .res_ready (rsp.ready),
        .res       (res)
    );

    assign rsp.action     = res.action;
    assign rsp.out_block  = res.out_block;
    assign rsp.out_size   = res.out_size;
    assign rsp.error_code = res.error_code;
    assign rsp.status     = res.status;

    assign end_act_ok    = (rsp.action == ACT_NONE) || (rsp.action == ACT_ACK) ||
                           (rsp.action == ACT_ERR);
    assign err_fields_ok = (rsp.status == ST_ABORT) && (rsp.out_block == '0);
    assign size_act_ok   = (rsp.action == ACT_DATA) || (rsp.action == ACT_STORE);

    // a finished or aborted transfer reports at most a final ack or an error
    `TLTE_ASSERT_IMPL(a_end_actions, rsp.valid && rsp.status != ST_BUSY, end_act_ok)
    `TLTE_ASSERT_IMPL(a_err_aborts, rsp.valid && rsp.action == ACT_ERR, err_fields_ok)
    `TLTE_ASSERT_IMPL(a_size_use, rsp.valid && rsp.out_size != '0, size_act_ok)
    `TLTE_ASSERT_NEXT(a_pop_loads, ev_pop, rsp.valid)

endmodule

FILE: tb/sv/tftp_lockstep_transfer_engine_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tftp_lockstep_transfer_engine_test
// Self-checking bench for the lock-step transfer engine. An internal model of
// the transfer state machine predicts one result per command transaction;
// results are checked in order. Directed sender, receiver and failure paths
// run first. Random transfers follow, steered by the predicted phase, under
// three idle mixes, with an output hold-off before the last mix.
// ----------------------------------------------------------------------------
module tftp_lockstep_transfer_engine_test;
    import tlte_pkg::*;

    localparam int CLK_HALF    = 5;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 200;
    localparam int MAX_REPORTS = 10;
    localparam int MODE_QUOTA  = 336;
    localparam int CHUNKS      = 8;
    localparam int SETTLE      = 8;

    localparam logic [SIZE_W-1:0] SEG_SIZE     = 10'd512;
    localparam logic [CMD_W-1:0]  CMD_UNUSED   = 3'd7;
    localparam logic [OP_W-1:0]   OP_UNUSED    = 3'd7;
    localparam logic [IOS_W-1:0]  IO_OTHER     = 2'd2;

    typedef enum logic [2:0] {
        XFER_IDLE,
        XFER_FETCHING,
        XFER_WAIT_ACK,
        XFER_WAIT_DATA,
        XFER_STORING,
        XFER_LINGER
    } xfer_phase_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    tlte_cmd_if cmd_ch ();
    tlte_res_if res_ch ();

    tftp_lockstep_transfer_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (res_ch)
    );

    cfg_t               eng_cfg = '{1'b0, 8'd5, 16'd25};
    xfer_phase_t        xfer_phase = XFER_IDLE;
    logic [BLOCK_W-1:0] xfer_block = '0;
    logic [SIZE_W-1:0]  xfer_size = '0;
    logic [TICK_W-1:0]  xfer_ticks = '0;
    logic [TOTAL_W-1:0] xfer_waited = '0;
    bit                 last_ignored;

    res_t pending_actions[$];

    int  snd_idle_pct = 12;
    int  rcv_idle_pct = 53;
    bit  hold_req = 1'b0;
    int  cycles = 0;
    int  sent_items = 0;
    int  acted_items = 0;
    int  checked_results = 0;
    int  fault_count = 0;

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tftp_lockstep_transfer_engine_test: no progress after %0d cycles", cycles);
            $display("tftp_lockstep_transfer_engine_test: done, errors");
            $finish;
        end
    end

    // transfer state machine prediction, one result per accepted command
    function automatic res_t engine_response(input logic [CMD_W-1:0] c,
                                             input logic [OP_W-1:0] op,
                                             input logic [BLOCK_W-1:0] blk,
                                             input logic [SIZE_W-1:0] raw_size,
                                             input logic [IOS_W-1:0] ios);
        res_t              r;
        logic [SIZE_W-1:0] sz;
        logic [BLOCK_W-1:0] prior;
        logic              listening;
        int unsigned       sum;
        r = '0;
        sz = (raw_size > SEG_SIZE) ? SEG_SIZE : raw_size;
        prior = xfer_block - 16'd1;
        listening = (xfer_phase == XFER_WAIT_ACK) || (xfer_phase == XFER_WAIT_DATA) ||
                    (xfer_phase == XFER_LINGER);
        last_ignored = 1'b0;
        if (c == CMD_START)
        begin
            xfer_ticks = '0;
            xfer_waited = '0;
            xfer_size = '0;
            xfer_block = 16'd1;
            if (!eng_cfg.direction)
            begin
                xfer_phase = XFER_FETCHING;
                r.action = ACT_FETCH;
                r.out_block = 16'd1;
            end
            else
            begin
                xfer_phase = XFER_WAIT_DATA;
                r.action = ACT_ACK;
            end
        end
        else if (c == CMD_TICK && listening)
        begin
            xfer_ticks = xfer_ticks + 8'd1;
            if (xfer_ticks >= eng_cfg.retransmit_ticks)
            begin
                xfer_ticks = '0;
                if (xfer_phase == XFER_LINGER)
                begin
                    xfer_phase = XFER_IDLE;
                    r.status = ST_DONE;
                end
                else
                begin
                    sum = xfer_waited + eng_cfg.retransmit_ticks;
                    xfer_waited = (sum > 32'hFFFF) ? 16'hFFFF : sum[15:0];
                    if (sum >= eng_cfg.total_timeout)
                    begin
                        xfer_phase = XFER_IDLE;
                        r.status = ST_ABORT;
                    end
                    else if (xfer_phase == XFER_WAIT_ACK)
                    begin
                        r.action = ACT_DATA;
                        r.out_block = xfer_block;
                        r.out_size = xfer_size;
                    end
                    else
                    begin
                        r.action = ACT_ACK;
                        r.out_block = prior;
                    end
                end
            end
        end
        else if (c == CMD_PACKET && listening)
        begin
            xfer_ticks = '0;
            if (xfer_phase == XFER_LINGER)
            begin
                xfer_phase = XFER_IDLE;
                r.status = ST_DONE;
                if (op == OP_DATA && blk == xfer_block)
                begin
                    r.action = ACT_ACK;
                    r.out_block = xfer_block;
                end
            end
            else if (op == OP_ERROR)
            begin
                xfer_phase = XFER_IDLE;
                r.status = ST_ABORT;
            end
            else if (xfer_phase == XFER_WAIT_ACK && op == OP_ACK)
            begin
                if (blk == xfer_block)
                begin
                    if (xfer_size < SEG_SIZE)
                    begin
                        xfer_phase = XFER_IDLE;
                        r.status = ST_DONE;
                    end
                    else
                    begin
                        xfer_block = xfer_block + 16'd1;
                        xfer_phase = XFER_FETCHING;
                        r.action = ACT_FETCH;
                        r.out_block = xfer_block;
                    end
                end
                else if (blk == prior)
                begin
                    r.action = ACT_DATA;
                    r.out_block = xfer_block;
                    r.out_size = xfer_size;
                end
            end
            else if (xfer_phase == XFER_WAIT_DATA && op == OP_DATA)
            begin
                if (blk == xfer_block)
                begin
                    xfer_size = sz;
                    xfer_phase = XFER_STORING;
                    r.action = ACT_STORE;
                    r.out_block = xfer_block;
                    r.out_size = sz;
                end
                else if (blk == prior)
                begin
                    r.action = ACT_ACK;
                    r.out_block = prior;
                end
            end
        end
        else if (c == CMD_FETCH_DONE && xfer_phase == XFER_FETCHING)
        begin
            if (ios != IO_OK)
            begin
                xfer_phase = XFER_IDLE;
                r.action = ACT_ERR;
                r.error_code = ERR_UNDEF;
                r.status = ST_ABORT;
            end
            else
            begin
                xfer_size = sz;
                xfer_ticks = '0;
                xfer_waited = '0;
                xfer_phase = XFER_WAIT_ACK;
                r.action = ACT_DATA;
                r.out_block = xfer_block;
                r.out_size = sz;
            end
        end
        else if (c == CMD_STORE_DONE && xfer_phase == XFER_STORING)
        begin
            if (ios != IO_OK)
            begin
                xfer_phase = XFER_IDLE;
                r.action = ACT_ERR;
                r.error_code = (ios == IO_NO_SPACE) ? ERR_DISK_FULL : ERR_UNDEF;
                r.status = ST_ABORT;
            end
            else
            begin
                xfer_ticks = '0;
                r.action = ACT_ACK;
                r.out_block = xfer_block;
                if (xfer_size == SEG_SIZE)
                begin
                    xfer_waited = '0;
                    xfer_block = xfer_block + 16'd1;
                    xfer_phase = XFER_WAIT_DATA;
                end
                else
                begin
                    xfer_phase = XFER_LINGER;
                end
            end
        end
        else
        begin
            last_ignored = 1'b1;
        end
        return r;
    endfunction

    task automatic send_item(input logic [CMD_W-1:0] c, input logic [OP_W-1:0] op,
                             input logic [BLOCK_W-1:0] blk, input logic [SIZE_W-1:0] sz,
                             input logic [IOS_W-1:0] ios);
        if ($urandom_range(99) < snd_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < snd_idle_pct);
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.command      <= c;
        cmd_ch.pkt_opcode   <= op;
        cmd_ch.pkt_block    <= blk;
        cmd_ch.payload_size <= sz;
        cmd_ch.io_status    <= ios;
        do @(posedge clk); while (!cmd_ch.ready);
        pending_actions.push_back(engine_response(c, op, blk, sz, ios));
        sent_items++;
        if (!last_ignored)
            acted_items++;
    endtask

    task automatic drain();
        cmd_ch.valid <= 1'b0;
        do @(posedge clk); while (pending_actions.size() != 0);
    endtask

    task automatic set_config(input logic dir, input logic [TICK_W-1:0] retx,
                              input logic [TOTAL_W-1:0] total);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DIRECTION;
        cfg_wdata <= {15'd0, dir};
        @(posedge clk);
        cfg_index <= REG_RETX;
        cfg_wdata <= {8'd0, retx};
        @(posedge clk);
        cfg_index <= REG_TOTAL;
        cfg_wdata <= total;
        @(posedge clk);
        cfg_we <= 1'b0;
        eng_cfg.direction = dir;
        eng_cfg.retransmit_ticks = retx;
        eng_cfg.total_timeout = total;
    endtask

    function automatic logic [SIZE_W-1:0] block_size();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 75)
            return SEG_SIZE;
        if (r < 95)
            return SIZE_W'($urandom_range(511));
        return SIZE_W'($urandom_range(1023, 513));
    endfunction

    // next command chosen from the predicted phase, mostly well-formed
    task automatic random_event();
        int unsigned        pick;
        logic [OP_W-1:0]    any_op;
        logic [OP_W-1:0]    want_op;
        logic [BLOCK_W-1:0] any_blk;
        logic [SIZE_W-1:0]  any_size;
        logic [IOS_W-1:0]   any_io;
        logic [CMD_W-1:0]   any_cmd;
        pick = $urandom_range(99);
        any_op = OP_W'($urandom_range(7));
        any_blk = BLOCK_W'($urandom_range(65535));
        any_size = SIZE_W'($urandom_range(1023));
        any_io = IOS_W'($urandom_range(2));
        any_cmd = CMD_W'($urandom_range(7));
        want_op = (xfer_phase == XFER_WAIT_ACK) ? OP_ACK : OP_DATA;
        case (xfer_phase)
            XFER_IDLE:
                if (pick < 85)
                    send_item(CMD_START, any_op, any_blk, any_size, any_io);
                else
                    send_item(any_cmd, any_op, any_blk, any_size, any_io);
            XFER_FETCHING:
                if (pick < 85)
                    send_item(CMD_FETCH_DONE, any_op, any_blk, block_size(), IO_OK);
                else if (pick < 91)
                    send_item(CMD_FETCH_DONE, any_op, any_blk, any_size,
                              IOS_W'($urandom_range(2, 1)));
                else
                    send_item(any_cmd, any_op, any_blk, any_size, any_io);
            XFER_WAIT_ACK, XFER_WAIT_DATA:
                if (pick < 62)
                    send_item(CMD_PACKET, want_op, xfer_block, block_size(), any_io);
                else if (pick < 70)
                    send_item(CMD_PACKET, want_op, xfer_block - 16'd1, block_size(), any_io);
                else if (pick < 84)
                    send_item(CMD_TICK, any_op, any_blk, any_size, any_io);
                else if (pick < 90)
                    send_item(CMD_PACKET, any_op, any_blk, any_size, any_io);
                else if (pick < 92)
                    send_item(CMD_PACKET, OP_ERROR, any_blk, any_size, any_io);
                else if (pick < 94)
                    send_item(CMD_START, any_op, any_blk, any_size, any_io);
                else
                    send_item(any_cmd, any_op, any_blk, any_size, any_io);
            XFER_STORING:
                if (pick < 85)
                    send_item(CMD_STORE_DONE, any_op, any_blk, any_size, IO_OK);
                else if (pick < 92)
                    send_item(CMD_STORE_DONE, any_op, any_blk, any_size,
                              IOS_W'($urandom_range(2, 1)));
                else
                    send_item(any_cmd, any_op, any_blk, any_size, any_io);
            default:
                if (pick < 40)
                    send_item(CMD_PACKET, OP_DATA, xfer_block, any_size, any_io);
                else if (pick < 70)
                    send_item(CMD_TICK, any_op, any_blk, any_size, any_io);
                else
                    send_item(CMD_PACKET, any_op, any_blk, any_size, any_io);
        endcase
    endtask

    task automatic test_sender_path();
        send_item(CMD_TICK, OP_ACK, 16'd0, 10'd0, IO_OK);
        send_item(CMD_UNUSED, OP_DATA, 16'hFFFF, 10'h3FF, IO_OTHER);
        send_item(CMD_START, OP_ACK, 16'd0, 10'd0, IO_OK);
        // oversized fetch is clipped to a full segment
        send_item(CMD_FETCH_DONE, OP_ACK, 16'd0, 10'h3FF, IO_OK);
        send_item(CMD_PACKET, OP_ACK, 16'd0, 10'd0, IO_OK);
        send_item(CMD_PACKET, OP_UNUSED, 16'd1, 10'd0, IO_OK);
        send_item(CMD_STORE_DONE, OP_ACK, 16'd1, 10'd0, IO_OK);
        send_item(CMD_PACKET, OP_ACK, 16'd1, 10'd0, IO_OK);
        send_item(CMD_FETCH_DONE, OP_ACK, 16'd0, 10'd0, IO_OK);
        send_item(CMD_PACKET, OP_ACK, 16'd2, 10'd0, IO_OK);
    endtask

    task automatic test_receiver_path();
        drain();
        set_config(1'b1, 8'd1, 16'hFFFF);
        send_item(CMD_START, OP_DATA, 16'd0, 10'd0, IO_OK);
        send_item(CMD_TICK, OP_DATA, 16'd0, 10'd0, IO_OK);
        send_item(CMD_PACKET, OP_DATA, 16'd1, SEG_SIZE, IO_OK);
        send_item(CMD_STORE_DONE, OP_DATA, 16'd0, 10'd0, IO_OK);
        send_item(CMD_PACKET, OP_DATA, 16'd1, SEG_SIZE, IO_OK);
        send_item(CMD_PACKET, OP_DATA, 16'd2, 10'd1, IO_OK);
        send_item(CMD_STORE_DONE, OP_DATA, 16'd0, 10'd0, IO_OK);
        // final block seen again while lingering
        send_item(CMD_PACKET, OP_DATA, 16'd2, 10'd1, IO_OK);
    endtask

    task automatic test_failure_paths();
        drain();
        set_config(1'b0, 8'd1, 16'd1);
        send_item(CMD_START, OP_ACK, 16'd0, 10'd0, IO_OK);
        send_item(CMD_FETCH_DONE, OP_ACK, 16'd0, 10'd7, IO_OK);
        send_item(CMD_TICK, OP_ACK, 16'd0, 10'd0, IO_OK);
        send_item(CMD_START, OP_ACK, 16'd0, 10'd0, IO_OK);
        send_item(CMD_FETCH_DONE, OP_ACK, 16'd0, 10'd0, IO_NO_SPACE);
        drain();
        set_config(1'b1, 8'd255, 16'd1);
        send_item(CMD_START, OP_DATA, 16'd0, 10'd0, IO_OK);
        send_item(CMD_PACKET, OP_DATA, 16'd1, 10'd9, IO_OK);
        send_item(CMD_STORE_DONE, OP_DATA, 16'd0, 10'd0, IO_NO_SPACE);
        send_item(CMD_START, OP_DATA, 16'd0, 10'd0, IO_OK);
        send_item(CMD_PACKET, OP_DATA, 16'd1, 10'd9, IO_OK);
        send_item(CMD_STORE_DONE, OP_DATA, 16'd0, 10'd0, IO_OTHER);
    endtask

    task automatic test_random_transfers(input int snd_pct, input int rcv_pct);
        int                 chunk;
        int                 target;
        logic [TICK_W-1:0]  retx;
        logic [TOTAL_W-1:0] total;
        snd_idle_pct = snd_pct;
        rcv_idle_pct = rcv_pct;
        for (chunk = 0; chunk < CHUNKS; chunk++)
        begin
            drain();
            case ($urandom_range(2))
                0: retx = 8'd1;
                1: retx = 8'd255;
                default: retx = TICK_W'($urandom_range(8, 1));
            endcase
            case ($urandom_range(2))
                0: total = 16'd1;
                1: total = 16'hFFFF;
                default: total = TOTAL_W'($urandom_range(40, 1));
            endcase
            if (chunk == 0)
            begin
                retx = 8'd255;
                total = 16'hFFFF;
            end
            set_config(1'($urandom_range(1)), retx, total);
            target = acted_items + MODE_QUOTA / CHUNKS;
            while (acted_items < target)
                random_event();
        end
    endtask

    task automatic test_backpressure();
        int k;
        drain();
        set_config(1'b0, 8'd3, 16'hFFFF);
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        hold_req = 1'b1;
        for (k = 0; k < 40; k++)
            random_event();
        // pause mid-transfer until all results are back
        drain();
        for (k = 0; k < 20; k++)
            random_event();
    endtask

    initial
    begin : result_ready
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            res_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    always @(posedge clk)
    begin : result_check
        res_t seen;
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.action     = res_ch.action;
            seen.out_block  = res_ch.out_block;
            seen.out_size   = res_ch.out_size;
            seen.error_code = res_ch.error_code;
            seen.status     = res_ch.status;
            if (pending_actions.size() == 0)
            begin
                fault_count++;
                if (fault_count <= MAX_REPORTS)
                    $display("%0t: unexpected result act=%0d blk=%0d size=%0d err=%0d st=%0d",
                             $realtime, seen.action, seen.out_block, seen.out_size,
                             seen.error_code, seen.status);
            end
            else
            begin
                want = pending_actions.pop_front();
                checked_results++;
                if (seen.action !== want.action || seen.out_block !== want.out_block ||
                    seen.out_size !== want.out_size || seen.error_code !== want.error_code ||
                    seen.status !== want.status)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch exp act=%0d blk=%0d size=%0d err=%0d st=%0d",
                                 $realtime, want.action, want.out_block, want.out_size,
                                 want.error_code, want.status);
                        $display("    got act=%0d blk=%0d size=%0d err=%0d st=%0d",
                                 seen.action, seen.out_block, seen.out_size,
                                 seen.error_code, seen.status);
                    end
                end
            end
        end
    end

    initial
    begin
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= '0;
        cfg_wdata           <= '0;
        cmd_ch.valid        <= 1'b0;
        cmd_ch.command      <= '0;
        cmd_ch.pkt_opcode   <= '0;
        cmd_ch.pkt_block    <= '0;
        cmd_ch.payload_size <= '0;
        cmd_ch.io_status    <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_sender_path();
        test_receiver_path();
        test_failure_paths();
        test_random_transfers(12, 53);
        test_random_transfers(53, 12);
        test_backpressure();
        test_random_transfers(0, 0);

        drain();
        repeat (SETTLE) @(posedge clk);
        $display("covered: directed send/receive/failure paths, random transfers in both directions");
        $display("  under three idle mixes and an output hold-off; %0d sent, %0d acted on, %0d checked",
                 sent_items, acted_items, checked_results);
        if (fault_count == 0 && pending_actions.size() == 0)
            $display("tftp_lockstep_transfer_engine_test: done, clean");
        else
            $display("tftp_lockstep_transfer_engine_test: done, errors");
        $finish;
    end

endmodule
